// ===== src/height_to_normal_map_defines.svh =====
// assertion macros for the height to normal map block
// no dependencies; included by the top level only
`ifndef HEIGHT_TO_NORMAL_MAP_DEFINES_SVH
`define HEIGHT_TO_NORMAL_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define HNM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HNM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define HNM_ASSERT(lbl, clk, rstn, prop, msg)
`define HNM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== src/hnm_pkg.sv =====
// shared types and constants for the height to normal map block
// no dependencies
package hnm_pkg;

  localparam logic [15:0] ZSCALE = 16'd65025;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_READ  = 11'b000_0000_0010,
    S_SHIFT = 11'b000_0000_0100,
    S_DIFF  = 11'b000_0000_1000,
    S_SUM   = 11'b000_0001_0000,
    S_VVA   = 11'b000_0010_0000,
    S_VVB   = 11'b000_0100_0000,
    S_SQ    = 11'b000_1000_0000,
    S_CMP   = 11'b001_0000_0000,
    S_STORE = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic shift;
    logic diff;
    logic sum;
    logic vva;
    logic vvb;
    logic sq;
    logic cmp;
    logic store;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic bit_last;
    logic comp_last;
  } stat_t;

endpackage

// ===== src/hnm_ctrl.sv =====
// controller state machine for the height to normal map block
// depends on hnm_pkg
module hnm_ctrl import hnm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  idle_o,
  output logic  out_valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = S_SHIFT;
      S_SHIFT: state_d = stat_i.produce ? S_DIFF : S_IDLE;
      S_DIFF:  state_d = S_SUM;
      S_SUM:   state_d = S_VVA;
      S_VVA:   state_d = S_VVB;
      S_VVB:   state_d = S_SQ;
      S_SQ:    state_d = S_CMP;
      S_CMP:   state_d = stat_i.bit_last ? S_STORE : S_SQ;
      S_STORE: state_d = stat_i.comp_last ? S_OUT : S_VVA;
      S_OUT:   if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd    = (state_q == S_READ);
    cmd_o.shift = (state_q == S_SHIFT);
    cmd_o.diff  = (state_q == S_DIFF);
    cmd_o.sum   = (state_q == S_SUM);
    cmd_o.vva   = (state_q == S_VVA);
    cmd_o.vvb   = (state_q == S_VVB);
    cmd_o.sq    = (state_q == S_SQ);
    cmd_o.cmp   = (state_q == S_CMP);
    cmd_o.store = (state_q == S_STORE);
  end

  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

// ===== src/hnm_datapath.sv =====
// datapath: counters, line buffers, window and exact unorm search
// depends on hnm_pkg
module hnm_datapath import hnm_pkg::*; #(
  parameter int MAX_WIDTH = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output stat_t      stat_o,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_data_i,
  input  logic [7:0] height_i,
  input  logic       frame_start_i,
  output logic [7:0] normal_x_o,
  output logic [7:0] normal_y_o,
  output logic [7:0] normal_z_o,
  output logic [8:0] pixel_column_o,
  output logic [8:0] pixel_row_o,
  output logic       frame_end_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (CW > 10) ? CW : 10;

  logic [9:0]    width_q;
  logic [XW-1:0] w_eff, wx;
  logic [AW-1:0] col_q, row_q, c0, r0, col_n, row_n, cur_c_q, cur_r_q;
  logic [7:0]    h_q;
  logic          produce_q, last_q;

  logic [7:0] above_mem [MAX_WIDTH];
  logic [7:0] mid_mem [MAX_WIDTH];
  logic [7:0] rd_above_q, rd_mid_q;

  logic [7:0] top_q [3];
  logic [7:0] cen_q [3];
  logic [7:0] bot_q [3];

  logic        a_neg_q, b_neg_q;
  logic [7:0]  a_mag_q, b_mag_q;
  logic [15:0] asq_q, bsq_q;
  logic [17:0] s_q;
  logic [15:0] uu_q;
  logic [31:0] vv_q;
  logic [13:0] sq_q;
  logic [6:0]  j_q, cand;
  logic [2:0]  bit_q;
  logic [1:0]  comp_q;
  logic [7:0]  u;
  logic        neg, ok;
  logic [33:0] prod;
  logic [7:0]  res;
  logic [8:0]  a_diff, b_diff;
  logic [XW-1:0] cm1, rm1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 10'd512;
    end else if (cfg_we_i) begin
      width_q <= cfg_data_i;
    end
  end

  // effective width clamped to 3..MAX_WIDTH
  always_comb begin
    wx = XW'(width_q);
    if (wx < XW'(3)) w_eff = XW'(3);
    else if (wx > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    else w_eff = wx;
  end

  always_comb begin
    c0 = frame_start_i ? '0 : col_q;
    r0 = frame_start_i ? '0 : row_q;
    if (XW'(c0) >= w_eff) c0 = '0;
    if (XW'(r0) >= w_eff) r0 = '0;
    col_n = c0;
    row_n = r0;
    if (XW'(c0) + XW'(1) >= w_eff) begin
      col_n = '0;
      row_n = (XW'(r0) + XW'(1) >= w_eff) ? '0 : r0 + AW'(1);
    end else begin
      col_n = c0 + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      produce_q <= 1'b0;
    end else if (cmd_i.load) begin
      col_q     <= col_n;
      row_q     <= row_n;
      produce_q <= (XW'(c0) >= XW'(2)) && (XW'(r0) >= XW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_c_q <= c0;
      cur_r_q <= r0;
      h_q     <= height_i;
      last_q  <= (XW'(c0) == w_eff - XW'(1)) && (XW'(r0) == w_eff - XW'(1));
    end
  end

  // line buffers
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) above_mem[cur_c_q] <= rd_mid_q;
    if (cmd_i.rd) rd_above_q <= above_mem[cur_c_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) mid_mem[cur_c_q] <= h_q;
    if (cmd_i.rd) rd_mid_q <= mid_mem[cur_c_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        top_q[i] <= '0;
        cen_q[i] <= '0;
        bot_q[i] <= '0;
      end
    end else if (cmd_i.shift) begin
      top_q[0] <= top_q[1];
      top_q[1] <= top_q[2];
      top_q[2] <= rd_above_q;
      cen_q[0] <= cen_q[1];
      cen_q[1] <= cen_q[2];
      cen_q[2] <= rd_mid_q;
      bot_q[0] <= bot_q[1];
      bot_q[1] <= bot_q[2];
      bot_q[2] <= h_q;
    end
  end

  assign a_diff = {1'b0, cen_q[0]} - {1'b0, cen_q[2]};
  assign b_diff = {1'b0, top_q[1]} - {1'b0, bot_q[1]};

  always_comb begin
    case (comp_q)
      2'd0:    begin u = a_mag_q; neg = a_neg_q; end
      2'd1:    begin u = b_mag_q; neg = b_neg_q; end
      default: begin u = 8'd255;  neg = 1'b0;    end
    endcase
  end

  assign cand = j_q | (7'd1 << bit_q);
  assign prod = {18'b0, sq_q, 2'b00} * {16'b0, s_q};
  assign ok   = neg ? (prod < {2'b0, vv_q}) : (prod <= {2'b0, vv_q});
  assign res  = neg ? (8'd127 - {1'b0, j_q}) : (8'd128 + {1'b0, j_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      a_neg_q <= a_diff[8];
      b_neg_q <= b_diff[8];
      a_mag_q <= a_diff[8] ? 8'(-a_diff) : a_diff[7:0];
      b_mag_q <= b_diff[8] ? 8'(-b_diff) : b_diff[7:0];
    end
    if (cmd_i.vva) begin
      s_q  <= 18'(asq_q) + 18'(bsq_q) + 18'(ZSCALE);
      uu_q <= {8'b0, u} * {8'b0, u};
    end
    if (cmd_i.vvb) begin
      vv_q  <= {16'b0, uu_q} * {16'b0, ZSCALE};
      j_q   <= '0;
      bit_q <= 3'd6;
    end
    if (cmd_i.sq) sq_q <= {7'b0, cand} * {7'b0, cand};
    if (cmd_i.cmp) begin
      if (ok) j_q <= cand;
      if (bit_q != 3'd0) bit_q <= bit_q - 3'd1;
    end
    if (cmd_i.store) begin
      case (comp_q)
        2'd0:    normal_x_o <= res;
        2'd1:    normal_y_o <= res;
        default: normal_z_o <= res;
      endcase
    end
  end

  // squares of the magnitudes, registered in the cycle after the differences
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      asq_q <= {8'b0, a_mag_q} * {8'b0, a_mag_q};
      bsq_q <= {8'b0, b_mag_q} * {8'b0, b_mag_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= '0;
    end else if (cmd_i.diff) begin
      comp_q <= '0;
    end else if (cmd_i.store) begin
      comp_q <= comp_q + 2'd1;
    end
  end

  assign cm1 = XW'(cur_c_q) - XW'(1);
  assign rm1 = XW'(cur_r_q) - XW'(1);
  assign pixel_column_o = cm1[8:0];
  assign pixel_row_o    = rm1[8:0];
  assign frame_end_o    = last_q;

  assign stat_o.produce   = produce_q;
  assign stat_o.bit_last  = (bit_q == 3'd0);
  assign stat_o.comp_last = (comp_q == 2'd2);

endmodule

// ===== src/height_to_normal_map.sv =====
// top level of the height to normal map block: handshakes and assertions
// depends on hnm_pkg, hnm_ctrl, hnm_datapath and height_to_normal_map_defines.svh
//
// central-difference normal map: 8-bit height samples come in raster order, one
// beat per pixel, and every interior pixel yields one beat carrying the unorm
// normal (x from left minus right, y from up minus down, z from 255), the pixel's
// column and row and a frame_end flag on the last interior pixel of the map.
// border pixels give no output beat. two line buffers (one memory each, read the
// cycle before write) and a 3x3 window supply the neighbors. the block works on
// one sample at a time; an interior sample also waits while its output beat is
// stalled. most of its work is the exact rounding search, a 7-step binary
// search per component through one shared 16x18 multiplier and compare, each step
// a square state then a compare state, three components per pixel.
// image_width may be written only while no sample is in flight.
`include "height_to_normal_map_defines.svh"
module height_to_normal_map import hnm_pkg::*; #(
  parameter int MAX_WIDTH = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] height_i,
  input  logic       frame_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] normal_x_o,
  output logic [7:0] normal_y_o,
  output logic [7:0] normal_z_o,
  output logic [8:0] pixel_column_o,
  output logic [8:0] pixel_row_o,
  output logic       frame_end_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  idle;

  hnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .idle_o      (idle),
    .out_valid_o (out_valid_o)
  );

  hnm_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .height_i       (height_i),
    .frame_start_i  (frame_start_i),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .frame_end_o    (frame_end_o)
  );

  // input side is open only while the controller is idle
  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;

  // a pending output beat keeps the input closed
  `HNM_ASSERT_IMP(a_out_blocks_in, clk_i, rst_ni, out_valid_o, in_stall_o, "input open with output pending")
  // z is never negative, so its unorm code sits in the upper half
  `HNM_ASSERT_IMP(a_z_upper, clk_i, rst_ni, out_valid_o, normal_z_o >= 8'd128, "normal z below midpoint")
  // the last interior pixel lies on the diagonal of a square map
  `HNM_ASSERT_IMP(a_end_diag, clk_i, rst_ni, out_valid_o && frame_end_o, pixel_column_o == pixel_row_o, "frame end off diagonal")

endmodule

// ===== tb/tb_height_to_normal_map.sv =====
// self-checking testbench for height_to_normal_map: directed table, then random
// height maps at many widths; depends on hnm_pkg and the block's rtl only
module tb_height_to_normal_map;
  import hnm_pkg::*;

  localparam int MAX_W = 512;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 80;  // ample for a trailing border sample to finish

  typedef struct packed {
    logic [7:0] nx;
    logic [7:0] ny;
    logic [7:0] nz;
    logic [8:0] col;
    logic [8:0] row;
    logic       fend;
  } normal_beat_t;

  typedef struct packed {
    logic [7:0] h;
    logic       fs;
    logic       typed;  // flat patch, normal read off directly
    logic [7:0] ex;
    logic [7:0] ey;
    logic [7:0] ez;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [9:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] height_i = '0;
  logic       frame_start_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] normal_x_o, normal_y_o, normal_z_o;
  logic [8:0] pixel_column_o, pixel_row_o;
  logic       frame_end_o;

  height_to_normal_map dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .height_i, .frame_start_i,
    .out_valid_o, .out_stall_i, .normal_x_o, .normal_y_o, .normal_z_o,
    .pixel_column_o, .pixel_row_o, .frame_end_o
  );

  always #10 clk_i = ~clk_i;

  // predictor state: own copy of line buffers, window and raster position
  logic [9:0] width_reg;
  logic [7:0] line_above [MAX_W];
  logic [7:0] line_middle [MAX_W];
  logic [7:0] win_top [3];
  logic [7:0] win_mid [3];
  logic [7:0] win_bot [3];
  int         col_pos, row_pos;

  normal_beat_t pending_normals [$];
  int  mismatches = 0;
  int  fails = 0;
  int  n_heights = 0;
  int  n_normals = 0;
  int  n_frame_ends = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;  // no idling on either side
  int  stall_left = 0;

  // exact round-half-up of 255*(1 + v/sqrt(s))/2 by counting thresholds
  function automatic logic [7:0] unorm_of(input int v, input longint s);
    int     cnt;
    int     m;
    longint vv, mm;
    bit     ok;
    cnt = 0;
    vv = longint'(v) * v * 65025;
    for (int k = 1; k <= 255; k++) begin
      m = 2 * k - 256;
      mm = longint'(m) * m * s;
      if (m <= 0 && v >= 0) ok = 1'b1;
      else if (m >= 0 && v < 0) ok = 1'b0;
      else if (m > 0) ok = (mm <= vv);
      else ok = (mm >= vv);
      if (ok) cnt++;
    end
    return cnt[7:0];
  endfunction

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  // advance the raster by one sample; returns 1 when an interior normal results
  function automatic bit predict_normal(input logic [7:0] h, input logic fs,
                                        output normal_beat_t nb);
    int     w, a, b;
    longint s;
    w = eff_width();
    nb = '0;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= w) row_pos = 0;
    win_top[0] = win_top[1]; win_top[1] = win_top[2];
    win_mid[0] = win_mid[1]; win_mid[1] = win_mid[2];
    win_bot[0] = win_bot[1]; win_bot[1] = win_bot[2];
    win_top[2] = line_above[col_pos];
    win_mid[2] = line_middle[col_pos];
    line_above[col_pos] = line_middle[col_pos];
    line_middle[col_pos] = h;
    win_bot[2] = h;
    predict_normal = 1'b0;
    if (col_pos >= 2 && row_pos >= 2) begin
      a = int'(win_mid[0]) - int'(win_mid[2]);   // left minus right
      b = int'(win_top[1]) - int'(win_bot[1]);   // up minus down
      s = longint'(a * a + b * b) + 65025;
      nb.nx = unorm_of(a, s);
      nb.ny = unorm_of(b, s);
      nb.nz = unorm_of(255, s);
      nb.col = 9'(col_pos - 1);
      nb.row = 9'(row_pos - 1);
      nb.fend = (col_pos == w - 1) && (row_pos == w - 1);
      predict_normal = 1'b1;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= w) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // hold the beat until accepted, then feed the predictor
  task automatic send_height(input logic [7:0] h, input logic fs,
                             input bit typed = 1'b0, input logic [23:0] typed_xyz = '0);
    bit           acc;
    normal_beat_t nb;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    height_i <= h;
    frame_start_i <= fs;
    do begin
      @(negedge clk_i);
      acc = !in_stall_o;
      @(posedge clk_i);
    end while (!acc);
    n_heights++;
    if (predict_normal(h, fs, nb)) begin
      if (typed) {nb.nx, nb.ny, nb.nz} = typed_xyz;
      pending_normals.push_back(nb);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write only once the block has gone idle
  task automatic write_width(input logic [9:0] v);
    bit acc;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    cfg_valid_i <= 1'b0;
    width_reg = v;
  endtask

  function automatic logic [7:0] pick_height();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // whole maps with random content; some start without frame_start (wrap),
  // some are cut short, and the next one then starts with frame_start
  task automatic run_maps(input int nmaps, input int hold_at = -1);
    int  w, n;
    bit  cut;
    logic fs;
    w = eff_width();
    cut = 1'b1;
    for (int f = 0; f < nmaps; f++) begin
      fs = cut || ($urandom_range(0, 1) == 1);
      n = w * w;
      cut = 1'b0;
      if (f != nmaps - 1 && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, w * w - 1);
        cut = 1'b1;
      end
      for (int p = 0; p < n; p++) begin
        if (p == hold_at && f == 0) begin
          // sender holds off until the block has delivered everything
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (pending_normals.size() != 0);
        end
        send_height(pick_height(), fs && p == 0);
      end
    end
  endtask

  task automatic run_rows(input int n, input logic fs_first);
    for (int p = 0; p < n; p++) send_height(pick_height(), fs_first && p == 0);
  endtask

  // directed 3x3 maps: flat, steepest positive slope, a cut map, steepest negative
  dir_row_t dir_tbl [29] = '{
    '{8'd100, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd100, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd100, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd100, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd100, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd100, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd100, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd100, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd100, 1'b0, 1'b1, 8'd128, 8'd128, 8'd255},
    '{8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd77, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd200, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd13, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd9, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}
  };

  // receiver: random stall bursts, none in the quiet tail
  always @(posedge clk_i) begin
    if (!rst_ni || quiet) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // outputs are stable from the falling edge to the accepting rising edge
  always @(negedge clk_i) begin
    normal_beat_t exp_nb, got_nb;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_nb = '{normal_x_o, normal_y_o, normal_z_o, pixel_column_o, pixel_row_o,
                 frame_end_o};
      if (pending_normals.size() == 0) begin
        fails++;
        if (mismatches++ < 10)
          $display("unexpected normal beat %p", got_nb);
      end else begin
        exp_nb = pending_normals.pop_front();
        n_normals++;
        if (exp_nb.fend) n_frame_ends++;
        if (got_nb !== exp_nb) begin
          fails++;
          if (mismatches++ < 10)
            $display("normal mismatch: expected %p, got %p", exp_nb, got_nb);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    width_reg = 10'd512;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < MAX_W; i++) begin
      line_above[i] = '0;
      line_middle[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      win_top[i] = '0; win_mid[i] = '0; win_bot[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the smallest map
    write_width(10'd3);
    foreach (dir_tbl[i])
      send_height(dir_tbl[i].h, dir_tbl[i].fs, dir_tbl[i].typed,
                  {dir_tbl[i].ex, dir_tbl[i].ey, dir_tbl[i].ez});

    // widths below the range clamp to 3, between small in-range widths
    write_width(10'd0);
    run_maps(3);
    write_width(10'd2);
    run_maps(2);
    write_width(10'd4);
    run_maps(4);
    write_width(10'd1);
    run_maps(2);
    write_width(10'd7);
    run_maps(3, 20);
    write_width(10'd5);
    run_maps(4);

    // shrink mid-map with the column beyond the new width
    write_width(10'd12);
    run_rows(3 * 12 + 9, 1'b1);
    write_width(10'd5);
    run_rows(30, 1'b0);
    // shrink mid-map with the row beyond the new width
    write_width(10'd12);
    run_rows(7 * 12 + 2, 1'b1);
    write_width(10'd4);
    run_rows(20, 1'b0);
    run_maps(2);

    // widest map: a few rows only, then all-ones register (clamps to the max)
    write_width(10'd512);
    run_rows(2 * 512 + 30, 1'b1);
    write_width(10'd1023);
    run_rows(20, 1'b1);

    // tail with no idling on either side
    write_width(10'd9);
    quiet = 1'b1;
    run_maps(2);

    in_valid_i <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_normals.size() != 0) fails++;

    $display("sent %0d height samples over widths 3..512, checked %0d normals",
             n_heights, n_normals);
    $display("%0d map ends seen, %0d failures", n_frame_ends, fails);
    if (fails == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/hnm_pkg.sv
src/hnm_ctrl.sv
src/hnm_datapath.sv
src/height_to_normal_map.sv
tb/tb_height_to_normal_map.sv
